// ===== rtl/hmqp_pkg.sv =====
// Shared types and constants for the quadratic-probe hash map block.
package hmqp_pkg;

    // Field widths of the request and response words.
    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_OUT_BITS = 7;

    // Request codes.
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_SET   = 1'b1;

    // Response status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] new_value;
    } hmqp_req_t;

    typedef struct packed {
        logic                      found;
        logic [VALUE_BITS-1:0]     read_value;
        logic                      status;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } hmqp_rsp_t;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic                  used;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } hmqp_slot_t;

endpackage

// ===== rtl/hmqp_mod_adder.sv =====
// Modular adder: (a + b + cin) mod MODULUS for operands below MODULUS.
module hmqp_mod_adder #(
    parameter int MODULUS = 251,
    parameter int W       = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         cin,
    output logic [W-1:0] sum
);
    localparam logic [W:0] MOD_V = (W+1)'(MODULUS);

    logic [W:0] raw;
    logic [W:0] reduced;

    // Both operands are below the modulus, so one conditional subtract suffices.
    assign raw     = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
    assign reduced = (raw >= MOD_V) ? (raw - MOD_V) : raw;
    assign sum     = reduced[W-1:0];

endmodule

// ===== rtl/hash_map_quadratic_probe_unit.sv =====
// Top level of the quadratic-probe hash map: sequencer, slot memory and response register.
// Steps in order: accept, key reduction modulo TABLE_SIZE (reciprocal multiply, back-multiply
// and subtract, final correction), then for each probe a registered slot memory read followed
// by compare and step, then a commit step and a response load step.
// Throughput: one word at a time; the next request is taken once the sequencer is idle again.
// Reset: control state clears at once, then a clearing pass zeroes every slot to clear the used bits.
module hash_map_quadratic_probe_unit #(
    parameter int TABLE_SIZE = 251
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hmqp_pkg::hmqp_req_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hmqp_pkg::hmqp_rsp_t m_data
);
    import hmqp_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [AW-1:0]       LAST_SLOT  = AW'(TABLE_SIZE - 1);
    localparam logic [AW-1:0]       LOAD_LIMIT = AW'((TABLE_SIZE - 1) / 2);
    localparam logic [AW:0]         MOD_V      = (AW+1)'(TABLE_SIZE);
    localparam logic [KEY_BITS-1:0] RECIP      =
        KEY_BITS'((64'(1) << KEY_BITS) / TABLE_SIZE);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_QUOT    = 9'b000000100,
        ST_REM     = 9'b000001000,
        ST_FIX     = 9'b000010000,
        ST_READ    = 9'b000100000,
        ST_CHECK   = 9'b001000000,
        ST_COMMIT  = 9'b010000000,
        ST_DELIVER = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        delta_reg, delta_next;
    logic [AW-1:0]        probe_reg, probe_next;
    logic [AW-1:0]        count_reg, count_next;
    logic                 do_write_reg, do_write_next;
    logic                 do_insert_reg, do_insert_next;
    logic                 m_valid_reg, m_valid_next;

    hmqp_req_t            req_reg, req_next;
    logic [AW:0]          quot_reg, quot_next;
    logic [AW:0]          rem_reg, rem_next;
    logic                 found_reg, found_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                 status_reg, status_next;
    hmqp_rsp_t            m_data_reg, m_data_next;

    hmqp_slot_t           slot_mem [TABLE_SIZE];
    hmqp_slot_t           rd_word_reg;
    hmqp_slot_t           wr_word;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    logic [AW-1:0]        add_a, add_b, add_sum;
    logic [AW:0]          delta_raw;
    logic                 key_match;
    logic [AW+COUNT_OUT_BITS-1:0] count_ext;
    logic [2*KEY_BITS-1:0] key_prod;
    logic [AW:0]          qt_low;

    // Modular adder: steps the probe position by the odd increment.
    hmqp_mod_adder #(
        .MODULUS (TABLE_SIZE),
        .W       (AW)
    ) u_mod_adder (
        .a   (add_a),
        .b   (add_b),
        .cin (1'b0),
        .sum (add_sum)
    );

    assign add_a = pos_reg;
    assign add_b = delta_reg;

    // Key reduction: the reciprocal estimate of the quotient is low by at most one,
    // so the remainder lands below twice the table size and is known from its low bits.
    assign key_prod = {{KEY_BITS{1'b0}}, req_reg.key} * {{KEY_BITS{1'b0}}, RECIP};
    assign qt_low   = quot_reg * MOD_V;

    // Odd increment between successive squares, kept reduced modulo the table size.
    assign delta_raw = {1'b0, delta_reg} + (AW+1)'(2);
    assign key_match = rd_word_reg.used && (rd_word_reg.key == req_reg.key);
    assign count_ext = {{COUNT_OUT_BITS{1'b0}}, count_reg};

    // Slot memory: one write port, one registered read port at the probe position.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= slot_mem[pos_reg];
    end

    // Memory write selection for the clearing pass and the commit step.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_word = '{used: 1'b1, key: req_reg.key, value: req_reg.new_value};
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_word = '0;
        end else if (state_reg == ST_COMMIT) begin
            wr_en   = do_write_reg;
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pos_next       = pos_reg;
        delta_next     = delta_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        do_write_next  = do_write_reg;
        do_insert_next = do_insert_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        req_next       = req_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        found_next     = found_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    delta_next = AW'(1);
                    probe_next = '0;
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT: begin
                // Only the low quotient bits matter for the remainder.
                quot_next  = key_prod[KEY_BITS+AW:KEY_BITS];
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = req_reg.key[AW:0] - qt_low;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                pos_next   = (rem_reg >= MOD_V) ? AW'(rem_reg - MOD_V) : rem_reg[AW-1:0];
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                do_write_next  = 1'b0;
                do_insert_next = 1'b0;
                found_next     = 1'b0;
                value_next     = '0;
                status_next    = STATUS_DONE;
                priority if (!rd_word_reg.used) begin
                    // Empty slot ends the walk; a set inserts here if the load allows.
                    if (req_reg.req_type == REQ_SET) begin
                        if (count_reg < LOAD_LIMIT) begin
                            do_write_next  = 1'b1;
                            do_insert_next = 1'b1;
                        end else begin
                            status_next = STATUS_REFUSED;
                        end
                    end
                    state_next = ST_COMMIT;
                end else if (key_match) begin
                    found_next    = 1'b1;
                    value_next    = rd_word_reg.value;
                    do_write_next = (req_reg.req_type == REQ_SET);
                    state_next    = ST_COMMIT;
                end else if (probe_reg == LAST_SLOT) begin
                    // Every probe hit another key.
                    if (req_reg.req_type == REQ_SET) begin
                        status_next = STATUS_REFUSED;
                    end
                    state_next = ST_COMMIT;
                end else begin
                    pos_next   = add_sum;
                    delta_next = (delta_raw >= MOD_V) ? AW'(delta_raw - MOD_V)
                                                      : delta_raw[AW-1:0];
                    probe_next = probe_reg + AW'(1);
                    state_next = ST_READ;
                end
            end
            ST_COMMIT: begin
                if (do_insert_reg) begin
                    count_next = count_reg + AW'(1);
                end
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                // Load the response word once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{found:       found_reg,
                                     read_value:  value_reg,
                                     status:      status_reg,
                                     entry_count: count_ext[COUNT_OUT_BITS-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            delta_reg     <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            do_write_reg  <= 1'b0;
            do_insert_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pos_reg       <= pos_next;
            delta_reg     <= delta_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            do_write_reg  <= do_write_next;
            do_insert_reg <= do_insert_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The held key count never passes the load limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LOAD_LIMIT)
        else $error("key count above load limit");

    // The key count moves only in the commit step.
    a_count_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMMIT) |=> $stable(count_reg))
        else $error("key count changed outside commit");

    // A word reporting a hit never reports a refused insert.
    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> (m_data.status == STATUS_DONE))
        else $error("hit reported with refused status");

    // The probe position always addresses a real slot during the walk.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (pos_reg <= LAST_SLOT))
        else $error("probe position outside table");

endmodule
